// ----- design/arle_pkg.sv -----
// Shared types and constants for the audit ring log engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package arle_pkg;

    // Width of the tally fields in a result beat.
    localparam int unsigned TALLY_W = 7;

    // Operation codes carried in the opcode field.
    typedef enum logic [3:0] {
        OP_RECORD  = 4'd0,
        OP_GET     = 4'd1,
        OP_COUNT   = 4'd2,
        OP_COUNTC  = 4'd3,
        OP_GETC    = 4'd4,
        OP_COUNTA  = 4'd5,
        OP_COUNTS  = 4'd6,
        OP_SUMMARY = 4'd7,
        OP_CLEAR   = 4'd8
    } op_t;

    // Input beat.
    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] action_code;
        logic [31:0] caller_id;
        logic [31:0] target_id;
        logic [63:0] aux_word;
        logic        success_flag;
        logic [15:0] position;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic               status;
        logic [31:0]        rec_seq;
        logic [31:0]        rec_action;
        logic [31:0]        rec_caller;
        logic [31:0]        rec_target;
        logic [63:0]        rec_aux;
        logic               rec_success;
        logic [TALLY_W-1:0] tally;
        logic [TALLY_W-1:0] pass_tally;
        logic [TALLY_W-1:0] fail_tally;
    } out_t;

    // One stored log entry, as held in the entry memory.
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] action;
        logic [31:0] caller;
        logic [31:0] target;
        logic [63:0] aux;
        logic        success;
    } entry_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESPOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic record;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pre_err;
        logic is_record;
        logic is_clear;
        logic do_scan;
        logic scan_last;
        logic out_free;
    } ctl_status_t;

endpackage

// ----- design/arle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the log entries for the datapath.
module arle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/arle_ctrl.sv -----
// Controller state machine of the audit ring log engine.
// Depends on arle_pkg for the state type and the command and status structs.
module arle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  arle_pkg::ctl_status_t status,
    output arle_pkg::ctl_cmd_t    cmd
);
    import arle_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.pre_err && status.do_scan) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_RESPOND;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DECODE: begin
                // The entry write, the clear and the scan set-up are exclusive.
                if (!status.pre_err) begin
                    cmd.record     = status.is_record;
                    cmd.clear      = status.is_clear;
                    cmd.scan_start = status.do_scan;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN: begin
                cmd = '0;
            end
            ST_RESPOND: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/arle_dp.sv -----
// Datapath of the audit ring log engine: ring pointers, entry memory, scan
// accumulators and the result register. Depends on arle_pkg and arle_ram.
module arle_dp #(
    parameter int unsigned LOG_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  arle_pkg::ctl_cmd_t    cmd,
    output arle_pkg::ctl_status_t status,
    input  arle_pkg::in_t         s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output arle_pkg::out_t        m_data
);
    import arle_pkg::*;

    localparam int unsigned IDX_W = $clog2(LOG_DEPTH);
    localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > 16) ? CNT_W : 16;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LOG_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(LOG_DEPTH);

    // Request and ring state.
    in_t              req_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] wr_slot_reg;
    logic [IDX_W-1:0] wr_slot_next;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      seq_reg;

    // Scan state.
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [CNT_W-1:0] rem_reg;
    logic             rd_valid_reg;
    logic [CNT_W-1:0] match_cnt_reg;
    logic             found_reg;
    entry_t           hit_reg;

    // Result register.
    logic             m_valid_reg;
    out_t             m_data_reg;
    out_t             out_next;

    // Decode and memory signals.
    logic             pre_err;
    logic             scan_op;
    logic             needs_hit;
    logic             match;
    logic             take_hit;
    logic [IDX_W:0]   get_sum;
    logic [IDX_W-1:0] first_slot;
    logic [CNT_W-1:0] first_rem;
    logic [CMP_W-1:0] nth_ext;
    entry_t           wr_entry;
    entry_t           rd_entry;

    // Operand checks and operation classes.
    always_comb begin
        pre_err   = 1'b0;
        scan_op   = 1'b0;
        needs_hit = 1'b0;
        unique case (req_reg.opcode)
            OP_RECORD: begin
                pre_err = (req_reg.action_code == '0);
            end
            OP_GET: begin
                pre_err   = (CMP_W'(req_reg.position) >= CMP_W'(count_reg));
                scan_op   = 1'b1;
                needs_hit = 1'b1;
            end
            OP_COUNT: begin
                pre_err = 1'b0;
            end
            OP_COUNTC: begin
                pre_err = (req_reg.caller_id == '0);
                scan_op = 1'b1;
            end
            OP_GETC: begin
                pre_err   = (req_reg.caller_id == '0);
                scan_op   = 1'b1;
                needs_hit = 1'b1;
            end
            OP_COUNTA: begin
                pre_err = (req_reg.action_code == '0);
                scan_op = 1'b1;
            end
            OP_COUNTS, OP_SUMMARY: begin
                scan_op = 1'b1;
            end
            OP_CLEAR: begin
                pre_err = 1'b0;
            end
            default: begin
                pre_err = 1'b1;
            end
        endcase
    end

    assign status.pre_err   = pre_err;
    assign status.is_record = (req_reg.opcode == OP_RECORD);
    assign status.is_clear  = (req_reg.opcode == OP_CLEAR);
    assign status.do_scan   = scan_op && (count_reg != '0);
    assign status.scan_last = (rem_reg == CNT_W'(1));
    assign status.out_free  = !m_valid_reg || m_ready;

    // First slot and read count of a scan; a get reads just its own slot.
    assign get_sum = {1'b0, head_reg} + (IDX_W + 1)'(req_reg.position[IDX_W-1:0]);
    always_comb begin
        if (req_reg.opcode == OP_GET) begin
            first_slot = (get_sum >= DEPTH_EXT) ? IDX_W'(get_sum - DEPTH_EXT)
                                                : get_sum[IDX_W-1:0];
            first_rem  = CNT_W'(1);
        end else begin
            first_slot = head_reg;
            first_rem  = count_reg;
        end
    end

    // Ring pointer increments with wrap.
    assign head_next    = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
    assign slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // Entry written by a record.
    always_comb begin
        wr_entry.seq     = seq_reg + 32'd1;
        wr_entry.action  = req_reg.action_code;
        wr_entry.caller  = req_reg.caller_id;
        wr_entry.target  = req_reg.target_id;
        wr_entry.aux     = req_reg.aux_word;
        wr_entry.success = req_reg.success_flag;
    end

    arle_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LOG_DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (cmd.record),
        .wr_addr (wr_slot_reg),
        .wr_data (wr_entry),
        .rd_en   (cmd.scan_step),
        .rd_addr (slot_reg),
        .rd_data (rd_entry)
    );

    // Match test on the entry returned by the memory.
    always_comb begin
        match = 1'b0;
        unique case (req_reg.opcode)
            OP_GET:             match = 1'b1;
            OP_COUNTC, OP_GETC: match = (rd_entry.caller == req_reg.caller_id);
            OP_COUNTA:          match = (rd_entry.action == req_reg.action_code);
            OP_COUNTS:          match = (rd_entry.success == req_reg.success_flag);
            OP_SUMMARY:         match = rd_entry.success;
            default:            match = 1'b0;
        endcase
    end

    assign nth_ext  = (req_reg.opcode == OP_GET) ? '0 : CMP_W'(req_reg.position);
    assign take_hit = rd_valid_reg && match && !found_reg
                      && (CMP_W'(match_cnt_reg) == nth_ext);

    // Request register.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_data;
        end
    end

    // Ring state: record, clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            wr_slot_reg <= '0;
            count_reg   <= '0;
            seq_reg     <= '0;
        end else if (cmd.clear) begin
            head_reg    <= '0;
            wr_slot_reg <= '0;
            count_reg   <= '0;
            seq_reg     <= '0;
        end else if (cmd.record) begin
            seq_reg     <= seq_reg + 32'd1;
            wr_slot_reg <= wr_slot_next;
            // Once full, the oldest entry is overwritten and the head moves on.
            if (count_reg == FULL_CNT) begin
                head_reg <= head_next;
            end else begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Scan address and read counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                rem_reg <= first_rem;
            end else if (cmd.scan_step) begin
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            slot_reg <= first_slot;
        end else if (cmd.scan_step) begin
            slot_reg <= slot_next;
        end
    end

    // Match counter and nth-match capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_cnt_reg <= '0;
            found_reg     <= 1'b0;
        end else if (cmd.accept) begin
            match_cnt_reg <= '0;
            found_reg     <= 1'b0;
        end else if (rd_valid_reg && match) begin
            match_cnt_reg <= match_cnt_reg + 1'b1;
            if (take_hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_reg <= rd_entry;
        end
    end

    // Result beat.
    always_comb begin
        out_next = '0;
        if (pre_err || (needs_hit && !found_reg)) begin
            out_next.status = 1'b1;
        end else begin
            unique case (req_reg.opcode)
                OP_GET, OP_GETC: begin
                    out_next.rec_seq     = hit_reg.seq;
                    out_next.rec_action  = hit_reg.action;
                    out_next.rec_caller  = hit_reg.caller;
                    out_next.rec_target  = hit_reg.target;
                    out_next.rec_aux     = hit_reg.aux;
                    out_next.rec_success = hit_reg.success;
                end
                OP_COUNT: begin
                    out_next.tally = TALLY_W'(count_reg);
                end
                OP_COUNTC, OP_COUNTA, OP_COUNTS: begin
                    out_next.tally = TALLY_W'(match_cnt_reg);
                end
                OP_SUMMARY: begin
                    out_next.tally      = TALLY_W'(count_reg);
                    out_next.pass_tally = TALLY_W'(match_cnt_reg);
                    out_next.fail_tally = TALLY_W'(count_reg - match_cnt_reg);
                end
                default: begin
                    out_next = '0;
                end
            endcase
        end
    end

    // Output register: holds the beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/audit_ring_log_engine.sv -----
// Audit ring log engine: a LOG_DEPTH-entry event log that overwrites its oldest
// entry once full. A record, a clear, a plain count or a rejected request goes
// from decode straight to the response; a get reads just its own slot, and the
// filtered counts, the summary and the nth-caller lookup read every stored
// entry once through the single read port of the entry memory (none on an empty
// log); a drain state follows each scan. Each request gives exactly one result
// beat, and the next request is taken while that beat still waits in the output
// register; a result that is ready before the previous beat has been taken holds
// the block until the sink takes it. The entry memory is not cleared after reset;
// only stored entries are ever read.
module audit_ring_log_engine #(
    parameter int unsigned LOG_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  arle_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output arle_pkg::out_t m_data
);
    import arle_pkg::*;

    ctl_cmd_t    ctl_cmd;
    ctl_status_t ctl_status;

    // Controller.
    arle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (ctl_status),
        .cmd     (ctl_cmd)
    );

    // Datapath.
    arle_dp #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctl_cmd),
        .status  (ctl_status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A beat taken closes the input until its result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice for one request");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.load_out |-> (!m_valid || m_ready))
        else $error("result beat overwritten before it was taken");

    // The last memory read ends the scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_cmd.scan_step && ctl_status.scan_last) |=> !ctl_cmd.scan_step)
        else $error("scan ran past the stored entries");

endmodule
